// File: sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Types, codes and constants shared by the event stream parser files.
// ----------------------------------------------------------------------------
package sse_pkg;

   // default depth of the event name store
   localparam int NAME_MAX_DEF = 32;

   // input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // result kinds
   localparam logic [1:0] OK_DATA   = 2'd0;
   localparam logic [1:0] OK_NAME   = 2'd1;
   localparam logic [1:0] OK_DONE   = 2'd2;
   localparam logic [1:0] OK_STATUS = 2'd3;

   // status codes
   localparam logic [2:0] SC_OK       = 3'd0;
   localparam logic [2:0] SC_NO_COLON = 3'd1;
   localparam logic [2:0] SC_UNKNOWN  = 3'd2;
   localparam logic [2:0] SC_UNTERM   = 3'd3;
   localparam logic [2:0] SC_TOO_LONG = 3'd4;

   // stream characters
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // field names, right aligned in the 40-bit field shift register
   localparam logic [39:0] FN_EVENT = 40'h6576656E74;
   localparam logic [39:0] FN_DATA  = 40'h0064617461;
   localparam logic [39:0] FN_ID    = 40'h0000006964;
   localparam logic [39:0] FN_RETRY = 40'h7265747279;
   localparam logic [2:0]  FN_MAX   = 3'd5;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [2:0] status_code;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERR,
      S_CR,
      S_BYTE,
      S_EOS,
      S_DISP,
      S_DISP_END
   } st_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_FIELD,
      PH_VALUE,
      PH_COMMENT
   } ph_type;

   typedef enum logic [1:0] {
      LF_EVENT,
      LF_DATA,
      LF_IGNORE
   } lfield_type;

endpackage

// File: sv/sse_ram.sv
// ----------------------------------------------------------------------------
// sse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sse_event_stream_parser_top.sv
// ----------------------------------------------------------------------------
// sse_event_stream_parser_top
// Byte-serial server-sent events parser with an event name store in RAM.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one stream byte or an end-of-stream mark per
// transfer; the rsp channel carries data bytes, event name bytes, event
// complete markers and status results, with last set on the final result
// of each input transfer. Both channels are valid/ready.
// Flow: an input item is taken in S_IDLE and worked on in the next cycle,
// and its result is then loaded into the output register. A held CR that
// turns out to be an ordinary byte is first worked on in S_CR. A blank line
// that dispatches an event walks the name store through its one read port,
// one name byte per result in S_DISP, then the complete marker in
// S_DISP_END.
// The block works on one item at a time; the next item is taken once the
// current item's last result has moved into the output register.
// Reset clears all parse state and any sticky error; the name store needs
// no clearing, only entries written since the last event line are read.
// When the receiver stalls, the result waits in the output register and
// the parser holds until it can hand over its next result.
// ----------------------------------------------------------------------------
module sse_event_stream_parser_top #(
   parameter int NAME_MAX = sse_pkg::NAME_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sse_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int CNT_W  = $clog2(NAME_MAX + 1);

   sse_pkg::st_type     st_ff, st_in;
   sse_pkg::ph_type     ph_ff, ph_in;
   sse_pkg::lfield_type lfield_ff, lfield_in;
   sse_pkg::req_type    item_ff, item_in;
   sse_pkg::rsp_type    rsp_data_ff, em_data;

   logic [2:0]       err_ff, err_in;
   logic [39:0]      chars_ff, chars_in;
   logic [2:0]       fcnt_ff, fcnt_in;
   logic             ftl_ff, ftl_in;
   logic             avs_ff, avs_in;
   logic             cr_ff, cr_in;
   logic             nlh_ff, nlh_in;
   logic             dseen_ff, dseen_in;
   logic [CNT_W-1:0] nlen_ff, nlen_in;
   logic [CNT_W-1:0] disp_idx_ff, disp_idx_in;
   logic [CNT_W-1:0] idx_next;
   logic             rsp_valid_ff, rsp_valid_in;

   logic              em_valid;
   logic              step_fail;
   logic              disp_start;
   logic              disp_more;
   logic              ord_do;
   logic              lend_do;
   logic [7:0]        ord_b;
   logic              out_free;
   logic              step_go;
   logic              pending;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   sse_ram #(
      .WIDTH (8),
      .DEPTH (NAME_MAX)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en & step_go),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en & step_go),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_go   = !em_valid || out_free;
   assign req_ready = (st_ff == sse_pkg::S_IDLE);
   assign pending   = dseen_ff || (nlen_ff != '0);
   assign idx_next  = disp_idx_ff + 1'b1;

   // datapath: one parse step per cycle unless the output stalls, at most one result
   always_comb begin
      ph_in       = ph_ff;
      err_in      = err_ff;
      chars_in    = chars_ff;
      fcnt_in     = fcnt_ff;
      ftl_in      = ftl_ff;
      lfield_in   = lfield_ff;
      avs_in      = avs_ff;
      cr_in       = cr_ff;
      nlh_in      = nlh_ff;
      dseen_in    = dseen_ff;
      nlen_in     = nlen_ff;
      disp_idx_in = disp_idx_ff;
      item_in     = item_ff;
      em_valid    = 1'b0;
      em_data     = '0;
      step_fail   = 1'b0;
      disp_start  = 1'b0;
      disp_more   = 1'b0;
      ord_do      = 1'b0;
      lend_do     = 1'b0;
      ord_b       = item_ff.byte_in;
      wr_en       = 1'b0;
      wr_addr     = nlen_ff[ADDR_W-1:0];
      wr_data     = item_ff.byte_in;
      rd_en       = 1'b0;
      rd_addr     = disp_idx_ff[ADDR_W-1:0];

      case (st_ff)
         sse_pkg::S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
            end
         end
         sse_pkg::S_ERR: begin
            em_valid            = 1'b1;
            em_data.out_kind    = sse_pkg::OK_STATUS;
            em_data.status_code = err_ff;
            em_data.last        = 1'b1;
         end
         sse_pkg::S_CR: begin
            cr_in  = 1'b0;
            ord_do = 1'b1;
            ord_b  = sse_pkg::CH_CR;
         end
         sse_pkg::S_BYTE: begin
            cr_in = (item_ff.byte_in == sse_pkg::CH_CR);
            if (item_ff.byte_in == sse_pkg::CH_LF) begin
               lend_do = 1'b1;
            end else if (item_ff.byte_in != sse_pkg::CH_CR) begin
               ord_do = 1'b1;
            end
         end
         sse_pkg::S_EOS: begin
            em_valid         = 1'b1;
            em_data.out_kind = sse_pkg::OK_STATUS;
            em_data.last     = 1'b1;
            if (ph_ff == sse_pkg::PH_FIELD) begin
               step_fail           = 1'b1;
               err_in              = sse_pkg::SC_NO_COLON;
               em_data.status_code = sse_pkg::SC_NO_COLON;
            end else begin
               ph_in = sse_pkg::PH_START;
               if (ph_ff == sse_pkg::PH_VALUE && lfield_ff == sse_pkg::LF_DATA) begin
                  nlh_in = 1'b1;
               end
               if (pending) begin
                  step_fail           = 1'b1;
                  err_in              = sse_pkg::SC_UNTERM;
                  em_data.status_code = sse_pkg::SC_UNTERM;
               end else begin
                  em_data.status_code = sse_pkg::SC_OK;
               end
            end
         end
         sse_pkg::S_DISP: begin
            em_valid         = 1'b1;
            em_data.out_kind = sse_pkg::OK_NAME;
            em_data.out_byte = rd_data;
            em_data.last     = 1'b0;
            disp_idx_in      = idx_next;
            disp_more        = (idx_next < nlen_ff);
            if (disp_more) begin
               rd_en   = 1'b1;
               rd_addr = idx_next[ADDR_W-1:0];
            end
         end
         sse_pkg::S_DISP_END: begin
            em_valid         = 1'b1;
            em_data.out_kind = sse_pkg::OK_DONE;
            em_data.last     = 1'b1;
            dseen_in         = 1'b0;
            nlh_in           = 1'b0;
            nlen_in          = '0;
         end
         default: begin
         end
      endcase

      if (ord_do) begin
         case (ph_ff)
            sse_pkg::PH_START: begin
               if (ord_b == sse_pkg::CH_COLON) begin
                  ph_in = sse_pkg::PH_COMMENT;
               end else begin
                  ph_in    = sse_pkg::PH_FIELD;
                  chars_in = {32'd0, ord_b};
                  fcnt_in  = 3'd1;
                  ftl_in   = 1'b0;
               end
            end
            sse_pkg::PH_FIELD: begin
               if (ord_b == sse_pkg::CH_COLON) begin
                  // resolve the field name
                  ph_in  = sse_pkg::PH_VALUE;
                  avs_in = 1'b1;
                  if (ftl_ff) begin
                     step_fail = 1'b1;
                  end else if (fcnt_ff == 3'd5 && chars_ff == sse_pkg::FN_EVENT) begin
                     lfield_in = sse_pkg::LF_EVENT;
                     nlen_in   = '0;
                  end else if (fcnt_ff == 3'd4 && chars_ff == sse_pkg::FN_DATA) begin
                     lfield_in = sse_pkg::LF_DATA;
                     dseen_in  = 1'b1;
                     if (nlh_ff) begin
                        nlh_in           = 1'b0;
                        em_valid         = 1'b1;
                        em_data.out_kind = sse_pkg::OK_DATA;
                        em_data.out_byte = sse_pkg::CH_LF;
                        em_data.last     = 1'b1;
                     end
                  end else if ((fcnt_ff == 3'd2 && chars_ff == sse_pkg::FN_ID) ||
                               (fcnt_ff == 3'd5 && chars_ff == sse_pkg::FN_RETRY)) begin
                     lfield_in = sse_pkg::LF_IGNORE;
                  end else begin
                     step_fail = 1'b1;
                  end
                  if (step_fail) begin
                     ph_in               = ph_ff;
                     avs_in              = avs_ff;
                     err_in              = sse_pkg::SC_UNKNOWN;
                     em_valid            = 1'b1;
                     em_data.out_kind    = sse_pkg::OK_STATUS;
                     em_data.status_code = sse_pkg::SC_UNKNOWN;
                     em_data.last        = 1'b1;
                  end
               end else if (fcnt_ff < sse_pkg::FN_MAX) begin
                  chars_in = {chars_ff[31:0], ord_b};
                  fcnt_in  = fcnt_ff + 3'd1;
               end else begin
                  ftl_in = 1'b1;
               end
            end
            sse_pkg::PH_VALUE: begin
               avs_in = 1'b0;
               // one space right after the colon is dropped
               if (!(avs_ff && ord_b == sse_pkg::CH_SPACE)) begin
                  case (lfield_ff)
                     sse_pkg::LF_EVENT: begin
                        if (nlen_ff >= CNT_W'(NAME_MAX)) begin
                           step_fail           = 1'b1;
                           avs_in              = avs_ff;
                           err_in              = sse_pkg::SC_TOO_LONG;
                           em_valid            = 1'b1;
                           em_data.out_kind    = sse_pkg::OK_STATUS;
                           em_data.status_code = sse_pkg::SC_TOO_LONG;
                           em_data.last        = 1'b1;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = nlen_ff[ADDR_W-1:0];
                           wr_data = ord_b;
                           nlen_in = nlen_ff + 1'b1;
                        end
                     end
                     sse_pkg::LF_DATA: begin
                        em_valid         = 1'b1;
                        em_data.out_kind = sse_pkg::OK_DATA;
                        em_data.out_byte = ord_b;
                        em_data.last     = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      if (lend_do) begin
         case (ph_ff)
            sse_pkg::PH_START: begin
               if (pending) begin
                  if (nlen_ff == '0) begin
                     em_valid         = 1'b1;
                     em_data.out_kind = sse_pkg::OK_DONE;
                     em_data.last     = 1'b1;
                     dseen_in         = 1'b0;
                     nlh_in           = 1'b0;
                  end else begin
                     // first name byte read is issued now, walk continues in S_DISP
                     disp_start  = 1'b1;
                     rd_en       = 1'b1;
                     rd_addr     = '0;
                     disp_idx_in = '0;
                  end
               end
            end
            sse_pkg::PH_FIELD: begin
               step_fail           = 1'b1;
               err_in              = sse_pkg::SC_NO_COLON;
               em_valid            = 1'b1;
               em_data.out_kind    = sse_pkg::OK_STATUS;
               em_data.status_code = sse_pkg::SC_NO_COLON;
               em_data.last        = 1'b1;
            end
            sse_pkg::PH_VALUE: begin
               if (lfield_ff == sse_pkg::LF_DATA) begin
                  nlh_in = 1'b1;
               end
               ph_in = sse_pkg::PH_START;
            end
            default: begin
               ph_in = sse_pkg::PH_START;
            end
         endcase
      end

      // a data CR is followed by more results unless the next byte is a CR again
      if (st_ff == sse_pkg::S_CR && !step_fail) begin
         em_data.last = (item_ff.kind == sse_pkg::KIND_BYTE) &&
                        (item_ff.byte_in == sse_pkg::CH_CR);
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         sse_pkg::S_IDLE: begin
            if (req_valid) begin
               if (err_ff != sse_pkg::SC_OK) begin
                  st_in = sse_pkg::S_ERR;
               end else if (req_data.kind == sse_pkg::KIND_BYTE) begin
                  if (cr_ff && req_data.byte_in != sse_pkg::CH_LF) begin
                     st_in = sse_pkg::S_CR;
                  end else begin
                     st_in = sse_pkg::S_BYTE;
                  end
               end else if (cr_ff) begin
                  st_in = sse_pkg::S_CR;
               end else begin
                  st_in = sse_pkg::S_EOS;
               end
            end
         end
         sse_pkg::S_CR: begin
            if (step_fail) begin
               st_in = sse_pkg::S_IDLE;
            end else if (item_ff.kind == sse_pkg::KIND_BYTE) begin
               st_in = sse_pkg::S_BYTE;
            end else begin
               st_in = sse_pkg::S_EOS;
            end
         end
         sse_pkg::S_BYTE: begin
            st_in = disp_start ? sse_pkg::S_DISP : sse_pkg::S_IDLE;
         end
         sse_pkg::S_DISP: begin
            st_in = disp_more ? sse_pkg::S_DISP : sse_pkg::S_DISP_END;
         end
         sse_pkg::S_ERR,
         sse_pkg::S_EOS,
         sse_pkg::S_DISP_END: begin
            st_in = sse_pkg::S_IDLE;
         end
         default: begin
            st_in = sse_pkg::S_IDLE;
         end
      endcase
   end

   // output register: loads a result, frees on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (em_valid && step_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= sse_pkg::S_IDLE;
         ph_ff        <= sse_pkg::PH_START;
         lfield_ff    <= sse_pkg::LF_EVENT;
         err_ff       <= sse_pkg::SC_OK;
         fcnt_ff      <= '0;
         ftl_ff       <= 1'b0;
         avs_ff       <= 1'b0;
         cr_ff        <= 1'b0;
         nlh_ff       <= 1'b0;
         dseen_ff     <= 1'b0;
         nlen_ff      <= '0;
         disp_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            st_ff       <= st_in;
            ph_ff       <= ph_in;
            lfield_ff   <= lfield_in;
            err_ff      <= err_in;
            fcnt_ff     <= fcnt_in;
            ftl_ff      <= ftl_in;
            avs_ff      <= avs_in;
            cr_ff       <= cr_in;
            nlh_ff      <= nlh_in;
            dseen_ff    <= dseen_in;
            nlen_ff     <= nlen_in;
            disp_idx_ff <= disp_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         chars_ff <= chars_in;
         item_ff  <= item_in;
      end
      if (em_valid && step_go) begin
         rsp_data_ff <= em_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != sse_pkg::SC_OK) |=> (err_ff == $past(err_ff)))
      else $error("sticky error code changed");

   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      nlen_ff <= CNT_W'(NAME_MAX))
      else $error("name length beyond store depth");

   a_disp_index: assert property (@(posedge clock) disable iff (reset)
      (st_ff == sse_pkg::S_DISP) |-> (disp_idx_ff < nlen_ff))
      else $error("name walk index past stored length");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == sse_pkg::OK_DONE) |-> rsp_data.last)
      else $error("event complete marker not flagged last");
`endif

endmodule
